// ===== rtl/core/cttt_pkg.sv =====
// Shared types and codes for the cooperative task timer table.
package cttt_pkg;

    // The number of results one dispatch request may give.
    localparam int MaxResults = 16;
    localparam int ResCntW = $clog2(MaxResults + 1);

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ADD      = 2'd1,
        MODE_DELETE   = 2'd2,
        MODE_DISPATCH = 2'd3
    } mode_e;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_FULL         = 3'd1,
        STATUS_NOT_FOUND    = 3'd2,
        STATUS_NONE_PENDING = 3'd3,
        STATUS_BAD_TAG      = 3'd4
    } status_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH,
        ST_DRAIN
    } state_e;

    typedef struct packed {
        logic [7:0]  tag;
        logic [23:0] countdown;
        logic [23:0] period;
        logic [7:0]  pending;
        logic [31:0] id;
    } slot_t;

    typedef struct packed {
        mode_e       mode;
        logic [7:0]  tag;
        logic [23:0] delay;
        logic [23:0] period;
        logic [31:0] target;
        logic [31:0] next_id;
        logic        found;
        logic        emit_full;
    } head_ctl_t;

    typedef struct packed {
        logic hit;
        logic emit;
    } head_evt_t;

    typedef struct packed {
        status_e     status;
        logic [31:0] issued_id;
        logic [7:0]  run_tag;
        logic [3:0]  slot_index;
        logic [31:0] elapsed;
        logic        last;
    } result_t;

endpackage

// ===== rtl/core/cooperative_task_timer_table_core.sv =====
// Top level of the cooperative task timer table.
// The task slots sit in a ring of cells that rotates by one slot per cycle while a
// request walks it, unless the output side stalls; the head slot passes through a
// single update unit and re-enters at the tail, so every request walks the whole
// table once and leaves it in its original order. A request passes from its
// acceptance through one rotation of the ring, a step that forms the final result
// and a step that hands it to the output register before the next is accepted.
// The walk halts while the output side stalls and a further dispatch result is
// found, and the hand-off waits for the output register to empty. The block accepts
// a new request while the previous result still waits in the output register.
// Results of a dispatch come in slot order, the final one with last set;
// slot_index carries the low four bits of the slot number.
module cooperative_task_timer_table_core
    import cttt_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  task_tag,
    input  logic [23:0] first_delay,
    input  logic [23:0] repeat_period,
    input  logic [31:0] target_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] issued_id,
    output logic [7:0]  run_tag,
    output logic [3:0]  slot_index,
    output logic [31:0] elapsed_ticks,
    output logic        last
);

    localparam int IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    state_e              state_reg, state_next;
    logic [IdxW-1:0]     step_reg, step_next;
    logic                found_reg, found_next;
    logic [IdxW-1:0]     fidx_reg, fidx_next;
    logic [ResCntW-1:0]  cnt_reg, cnt_next;
    logic [31:0]         tick_reg, tick_next;
    logic [31:0]         nid_reg, nid_next;
    logic                hold_v_reg, hold_v_next;
    logic                outv_reg, outv_next;

    result_t             hold_reg, hold_next;
    result_t             out_reg, out_next;
    mode_e               mode_reg, mode_next;
    logic [7:0]          tag_reg, tag_next;
    logic [23:0]         delay_reg, delay_next;
    logic [23:0]         period_reg, period_next;
    logic [31:0]         target_reg, target_next;

    logic                shift;
    logic                move;
    logic                out_free;
    logic                stall;

    slot_t               ring_q [NUM_SLOTS];
    slot_t               head_out;
    head_ctl_t           ctl;
    head_evt_t           evt;

    // Cell i takes from cell i+1; the last cell takes the updated head slot.
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_ring
        slot_t cell_d;
        if (i == NUM_SLOTS - 1)
        begin : g_tail
            assign cell_d = head_out;
        end
        else
        begin : g_mid
            assign cell_d = ring_q[i+1];
        end
        cttt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (cell_d),
            .q     (ring_q[i])
        );
    end

    always_comb
    begin
        ctl.mode      = mode_reg;
        ctl.tag       = tag_reg;
        ctl.delay     = delay_reg;
        ctl.period    = period_reg;
        ctl.target    = target_reg;
        ctl.next_id   = nid_reg;
        ctl.found     = found_reg;
        ctl.emit_full = (cnt_reg == ResCntW'(MaxResults));
    end

    cttt_head u_head (
        .slot_in  (ring_q[0]),
        .ctl      (ctl),
        .slot_out (head_out),
        .evt      (evt)
    );

    assign out_free = !outv_reg || out_ready;
    assign stall    = evt.emit && hold_v_reg && !out_free;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        cnt_next    = cnt_reg;
        tick_next   = tick_reg;
        nid_next    = nid_reg;
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        outv_next   = outv_reg;
        out_next    = out_reg;
        mode_next   = mode_reg;
        tag_next    = tag_reg;
        delay_next  = delay_reg;
        period_next = period_reg;
        target_next = target_reg;
        shift       = 1'b0;
        move        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = mode_e'(mode);
                    tag_next    = task_tag;
                    delay_next  = first_delay;
                    period_next = repeat_period;
                    target_next = target_id;
                    step_next   = '0;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    cnt_next    = '0;
                    if (mode_e'(mode) == MODE_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!stall)
                begin
                    shift = 1'b1;
                    if (evt.hit)
                    begin
                        found_next = 1'b1;
                        fidx_next  = step_reg;
                    end
                    if (evt.emit)
                    begin
                        // The earlier dispatch result is known not to be the
                        // final one now, so it may go out.
                        move                 = hold_v_reg;
                        hold_v_next          = 1'b1;
                        hold_next.status     = STATUS_OK;
                        hold_next.issued_id  = ring_q[0].id;
                        hold_next.run_tag    = ring_q[0].tag;
                        hold_next.slot_index = 4'(step_reg);
                        hold_next.elapsed    = tick_reg;
                        hold_next.last       = 1'b0;
                        cnt_next             = cnt_reg + ResCntW'(1);
                    end
                    if (step_reg == IdxW'(NUM_SLOTS - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        step_next = step_reg + IdxW'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                hold_v_next          = 1'b1;
                hold_next.status     = STATUS_OK;
                hold_next.issued_id  = 32'd0;
                hold_next.run_tag    = 8'd0;
                hold_next.slot_index = 4'd0;
                hold_next.elapsed    = tick_reg;
                hold_next.last       = 1'b1;
                unique case (mode_reg)
                    MODE_TICK:
                    begin
                        hold_next.status = STATUS_OK;
                    end
                    MODE_ADD:
                    begin
                        priority if (tag_reg == 8'd0)
                        begin
                            hold_next.status = STATUS_BAD_TAG;
                        end
                        else if (!found_reg)
                        begin
                            hold_next.status = STATUS_FULL;
                        end
                        else
                        begin
                            hold_next.issued_id  = nid_reg;
                            hold_next.slot_index = 4'(fidx_reg);
                            nid_next             = nid_reg + 32'd1;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (found_reg)
                        begin
                            hold_next.slot_index = 4'(fidx_reg);
                        end
                        else
                        begin
                            hold_next.status = STATUS_NOT_FOUND;
                        end
                    end
                    MODE_DISPATCH:
                    begin
                        if (hold_v_reg)
                        begin
                            hold_next      = hold_reg;
                            hold_next.last = 1'b1;
                        end
                        else
                        begin
                            hold_next.status = STATUS_NONE_PENDING;
                        end
                    end
                    default:
                    begin
                        hold_next.status = STATUS_OK;
                    end
                endcase
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    move        = 1'b1;
                    hold_v_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (move)
        begin
            out_next  = hold_reg;
            outv_next = 1'b1;
        end
        else if (out_ready)
        begin
            outv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            found_reg  <= 1'b0;
            fidx_reg   <= '0;
            cnt_reg    <= '0;
            tick_reg   <= 32'd0;
            nid_reg    <= 32'd1;
            hold_v_reg <= 1'b0;
            outv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            found_reg  <= found_next;
            fidx_reg   <= fidx_next;
            cnt_reg    <= cnt_next;
            tick_reg   <= tick_next;
            nid_reg    <= nid_next;
            hold_v_reg <= hold_v_next;
            outv_reg   <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        out_reg    <= out_next;
        mode_reg   <= mode_next;
        tag_reg    <= tag_next;
        delay_reg  <= delay_next;
        period_reg <= period_next;
        target_reg <= target_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = outv_reg;
    assign status        = out_reg.status;
    assign issued_id     = out_reg.issued_id;
    assign run_tag       = out_reg.run_tag;
    assign slot_index    = out_reg.slot_index;
    assign elapsed_ticks = out_reg.elapsed;
    assign last          = out_reg.last;

endmodule

// ===== rtl/core/cttt_cell.sv =====
// One slot stage of the rotating task table.
module cttt_cell
    import cttt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  slot_t d,
    output slot_t q
);

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (shift)
        begin
            slot_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign q = slot_reg;

endmodule

// ===== rtl/core/cttt_head.sv =====
// Update logic for the slot that sits at the head of the ring.
module cttt_head
    import cttt_pkg::*;
(
    input  slot_t     slot_in,
    input  head_ctl_t ctl,
    output slot_t     slot_out,
    output head_evt_t evt
);

    logic occupied;

    assign occupied = (slot_in.tag != 8'd0);

    always_comb
    begin
        slot_out = slot_in;
        evt      = '0;
        unique case (ctl.mode)
            MODE_TICK:
            begin
                if (occupied)
                begin
                    if (slot_in.countdown == 24'd0)
                    begin
                        if (slot_in.pending != 8'hFF)
                        begin
                            slot_out.pending = slot_in.pending + 8'd1;
                        end
                        if (slot_in.period != 24'd0)
                        begin
                            slot_out.countdown = slot_in.period;
                        end
                    end
                    else
                    begin
                        slot_out.countdown = slot_in.countdown - 24'd1;
                    end
                end
            end
            MODE_ADD:
            begin
                if (!ctl.found && ctl.tag != 8'd0 && !occupied)
                begin
                    slot_out.tag       = ctl.tag;
                    slot_out.countdown = ctl.delay;
                    slot_out.period    = ctl.period;
                    slot_out.pending   = 8'd0;
                    slot_out.id        = ctl.next_id;
                    evt.hit            = 1'b1;
                end
            end
            MODE_DELETE:
            begin
                if (!ctl.found && occupied && slot_in.id == ctl.target)
                begin
                    slot_out = '0;
                    evt.hit  = 1'b1;
                end
            end
            MODE_DISPATCH:
            begin
                if (slot_in.pending != 8'd0 && !ctl.emit_full)
                begin
                    evt.emit         = 1'b1;
                    slot_out.pending = slot_in.pending - 8'd1;
                    // A one-shot task leaves the table once it has run.
                    if (slot_in.period == 24'd0)
                    begin
                        slot_out = '0;
                    end
                end
            end
            default:
            begin
                slot_out = slot_in;
            end
        endcase
    end

endmodule

// ===== rtl/core/cttt_checker.sv =====
// Port-level checks for the cooperative task timer table, bound to the top level.
module cttt_checker
    import cttt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] issued_id,
    input logic [7:0]  run_tag,
    input logic [3:0]  slot_index,
    input logic [31:0] elapsed_ticks,
    input logic        last
);

    // A result held against backpressure stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(issued_id) && $stable(run_tag) && $stable(slot_index)
            && $stable(elapsed_ticks) && $stable(last))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= STATUS_BAD_TAG)
        else $error("status code out of range");

    // Every failure is the only result of its request.
    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> last)
        else $error("failure result without last");

    a_none_pending_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_NONE_PENDING
            |-> issued_id == 32'd0 && run_tag == 8'd0 && slot_index == 4'd0)
        else $error("empty dispatch result carries data");

    // Each request walks the whole table, so acceptance never repeats at once.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted in consecutive cycles");

endmodule

bind cooperative_task_timer_table_core cttt_checker u_cttt_checker (.*);
